@@ rtl/c8ex_pkg.sv @@
`timescale 1ns / 1ps
package c8ex_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);
    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 32;

    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_WRMEM = 2'd1;
    localparam logic [1:0] MODE_RDROW = 2'd2;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OVER = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;
    localparam logic [1:0] FAULT_UNK = 2'd3;

    localparam logic [11:0] START_RESET = 12'd512;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic [63:0] row_data;
        logic        screen_changed;
        logic        key_wait;
        logic        delay_load;
        logic        sound_load;
        logic [7:0]  timer_value;
        logic [1:0]  fault;
    } t_result;
endpackage

@@ rtl/chip8_instruction_execute_unit.sv @@
`timescale 1ns / 1ps
// multi-step opcodes: 00E0 clears the framebuffer row by row, DXYN reads, loads and XORs
// each sprite row, FX33 writes three digits, FX55/FX65 move V0..VX (one memory port)
// flow: one word at a time, next word taken once the result register is free
// reset: synchronous active low; clears registers, stack pointer, pc to 512,
// and runs a framebuffer clearing pass over all 32 rows during which no word is taken
module chip8_instruction_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_start_address,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_instruction,
    input  logic [7:0]  i_random_byte,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_delay_now,
    input  logic [11:0] i_access_address,
    input  logic [7:0]  i_load_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_next_pc,
    output logic [15:0] o_index_value,
    output logic [63:0] o_row_data,
    output logic        o_screen_changed,
    output logic        o_key_wait,
    output logic        o_delay_load,
    output logic        o_sound_load,
    output logic [7:0]  o_timer_value,
    output logic [1:0]  o_fault
);
    import c8ex_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_DRD   = 4'd3;
    localparam logic [3:0] S_DROW  = 4'd4;
    localparam logic [3:0] S_DXOR  = 4'd5;
    localparam logic [3:0] S_BCD   = 4'd6;
    localparam logic [3:0] S_STO   = 4'd7;
    localparam logic [3:0] S_LDR   = 4'd8;
    localparam logic [3:0] S_LDW   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_RROW  = 4'd11;
    localparam logic [3:0] S_RDONE = 4'd12;

    logic [3:0]  r_state, n_state;
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [SP_W-1:0] r_sp;
    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  r_mem [MEM_BYTES];
    logic [63:0] r_fb [SCREEN_H];

    logic [1:0]  r_mode;
    logic [15:0] r_op;
    logic [7:0]  r_rnd, r_dly;
    logic [15:0] r_keys;
    logic [11:0] r_addr;
    logic [4:0]  r_cnt;
    logic        r_hit, r_chg;
    logic [7:0]  r_mdat;
    logic [63:0] r_rowd;
    logic [7:0]  r_bcd;
    logic        r_ovalid;
    t_result     r_res;

    logic [3:0] w_x, w_y, w_n;
    logic [7:0] w_nn, w_vx, w_vy;
    logic [11:0] w_nnn, w_pc2;
    assign w_x = r_op[11:8];
    assign w_y = r_op[7:4];
    assign w_n = r_op[3:0];
    assign w_nn = r_op[7:0];
    assign w_nnn = r_op[11:0];
    assign w_vx = r_v[w_x];
    assign w_vy = r_v[w_y];
    assign w_pc2 = r_pc + 12'd2;

    // shared memory port
    logic        w_mwe;
    logic [11:0] w_maddr;
    logic [7:0]  w_mwd;
    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_mem[w_maddr] <= w_mwd;
        end
        r_mdat <= r_mem[w_maddr];
    end

    logic [4:0] w_row;
    logic [63:0] w_mask;
    logic [63:0] w_spr;
    always_comb begin
        w_row = 5'(w_vy + 8'(r_cnt));
        w_spr = {r_mdat, 56'd0};
        w_mask = (w_spr >> w_vx[5:0]) | (w_spr << (7'd64 - {1'b0, w_vx[5:0]}));
    end

    logic w_in_acc;
    assign o_stall = (r_state != S_IDLE) || r_ovalid || !i_rst_n;
    assign w_in_acc = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;

    logic [3:0] w_key;
    logic       w_anykey;
    always_comb begin
        w_key = 4'd0;
        w_anykey = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                w_key = 4'(k);
                w_anykey = 1'b1;
            end
        end
    end

    always_comb begin
        w_mwe = 1'b0;
        w_maddr = r_i[11:0] + 12'(r_cnt);
        w_mwd = r_v[r_cnt[3:0]];
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                w_maddr = i_access_address;
                w_mwd = i_load_data;
                if (w_in_acc) begin
                    n_state = (i_mode == MODE_RDROW) ? S_RROW : S_DEC;
                    w_mwe = (i_mode == MODE_WRMEM);
                end
            end
            S_BCD: begin
                w_mwe = 1'b1;
                w_mwd = r_bcd;
            end
            S_STO: w_mwe = 1'b1;
            default: ;
        endcase
    end

    logic [8:0] w_sum;
    logic [7:0] w_q;
    always_comb begin
        w_sum = 9'(w_vx) + 9'(w_vy);
        w_q = 8'(w_vx >= 8'd200 ? 2 : (w_vx >= 8'd100 ? 1 : 0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            r_pc <= START_RESET;
            r_i <= '0;
            r_sp <= '0;
            r_ovalid <= 1'b0;
            r_res <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc <= i_cfg_start_address;
            end
            case (r_state)
                S_CLR: begin
                    r_fb[r_cnt] <= '0;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SCREEN_H - 1)) begin
                        r_state <= (r_mode == MODE_EXEC && r_op == 16'h00E0) &&
                                   r_res.fault == FAULT_UNK ? S_DONE : S_IDLE;
                        if (r_res.fault == FAULT_UNK) r_res.fault <= FAULT_NONE;
                    end
                    if (r_fb[r_cnt] != '0) r_chg <= 1'b1;
                end
                S_IDLE: begin
                    r_mode <= i_mode;
                    r_op <= i_instruction;
                    r_rnd <= i_random_byte;
                    r_keys <= i_keys_down;
                    r_dly <= i_delay_now;
                    r_addr <= i_access_address;
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    r_chg <= 1'b0;
                end
                S_RROW: begin
                    r_rowd <= (r_addr < 12'(SCREEN_H)) ? r_fb[r_addr[4:0]] : '0;
                    r_state <= S_RDONE;
                end
                S_RDONE: begin
                    r_res <= '{next_pc: r_pc, index_value: r_i, row_data: r_rowd,
                               default: '0};
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DEC: begin
                    r_res <= '{next_pc: r_pc, index_value: r_i, default: '0};
                    r_state <= S_DONE;
                    if (r_mode == MODE_EXEC) begin
                        r_pc <= w_pc2;
                        case (r_op[15:12])
                            4'h0: begin
                                if (r_op == 16'h00E0) begin
                                    r_res.fault <= FAULT_UNK;
                                    r_state <= S_CLR;
                                end else if (r_op == 16'h00EE) begin
                                    if (r_sp == '0) r_res.fault <= FAULT_UNDER;
                                    else begin
                                        r_sp <= r_sp - 1'b1;
                                        r_pc <= r_stack[SI_W'(r_sp - 1'b1)];
                                    end
                                end else r_res.fault <= FAULT_UNK;
                            end
                            4'h1: r_pc <= w_nnn;
                            4'h2: begin
                                if (r_sp >= SP_W'(STACK_DEPTH)) r_res.fault <= FAULT_OVER;
                                else begin
                                    r_stack[SI_W'(r_sp)] <= w_pc2;
                                    r_sp <= r_sp + 1'b1;
                                    r_pc <= w_nnn;
                                end
                            end
                            4'h3: if (w_vx == w_nn) r_pc <= w_pc2 + 12'd2;
                            4'h4: if (w_vx != w_nn) r_pc <= w_pc2 + 12'd2;
                            4'h5: begin
                                if (w_n != 4'd0) r_res.fault <= FAULT_UNK;
                                else if (w_vx == w_vy) r_pc <= w_pc2 + 12'd2;
                            end
                            4'h6: r_v[w_x] <= w_nn;
                            4'h7: r_v[w_x] <= w_vx + w_nn;
                            4'h8: begin
                                case (w_n)
                                    4'h0: r_v[w_x] <= w_vy;
                                    4'h1: r_v[w_x] <= w_vx | w_vy;
                                    4'h2: r_v[w_x] <= w_vx & w_vy;
                                    4'h3: r_v[w_x] <= w_vx ^ w_vy;
                                    4'h4: begin
                                        r_v[w_x] <= w_sum[7:0];
                                        r_v[15] <= {7'd0, w_sum[8]};
                                    end
                                    4'h5: begin
                                        r_v[w_x] <= w_vx - w_vy;
                                        r_v[15] <= {7'd0, w_vx >= w_vy};
                                    end
                                    4'h6: begin
                                        r_v[w_x] <= w_vx >> 1;
                                        r_v[15] <= {7'd0, w_vx[0]};
                                    end
                                    4'h7: begin
                                        r_v[w_x] <= w_vy - w_vx;
                                        r_v[15] <= {7'd0, w_vy >= w_vx};
                                    end
                                    4'hE: begin
                                        r_v[w_x] <= w_vx << 1;
                                        r_v[15] <= {7'd0, w_vx[7]};
                                    end
                                    default: r_res.fault <= FAULT_UNK;
                                endcase
                            end
                            4'h9: begin
                                if (w_n != 4'd0) r_res.fault <= FAULT_UNK;
                                else if (w_vx != w_vy) r_pc <= w_pc2 + 12'd2;
                            end
                            4'hA: r_i <= {4'd0, w_nnn};
                            4'hB: r_pc <= w_nnn + 12'(r_v[0]);
                            4'hC: r_v[w_x] <= r_rnd & w_nn;
                            4'hD: begin
                                if (w_n == 4'd0) r_v[15] <= '0;
                                else r_state <= S_DRD;
                            end
                            4'hE: begin
                                if (w_nn == 8'h9E) begin
                                    if (r_keys[w_vx[3:0]]) r_pc <= w_pc2 + 12'd2;
                                end else if (w_nn == 8'hA1) begin
                                    if (!r_keys[w_vx[3:0]]) r_pc <= w_pc2 + 12'd2;
                                end else r_res.fault <= FAULT_UNK;
                            end
                            default: begin
                                case (w_nn)
                                    8'h07: r_v[w_x] <= r_dly;
                                    8'h0A: begin
                                        if (w_anykey) r_v[w_x] <= {4'd0, w_key};
                                        else begin
                                            r_pc <= r_pc;
                                            r_res.key_wait <= 1'b1;
                                        end
                                    end
                                    8'h15: begin
                                        r_res.delay_load <= 1'b1;
                                        r_res.timer_value <= w_vx;
                                    end
                                    8'h18: begin
                                        r_res.sound_load <= 1'b1;
                                        r_res.timer_value <= w_vx;
                                    end
                                    8'h1E: r_i <= r_i + 16'(w_vx);
                                    8'h29: r_i <= 16'(w_vx[3:0]) * 16'd5;
                                    8'h33: begin
                                        r_bcd <= w_q;
                                        r_rnd <= w_vx - (w_q == 8'd2 ? 8'd200 :
                                                 (w_q == 8'd1 ? 8'd100 : 8'd0));
                                        r_state <= S_BCD;
                                    end
                                    8'h55: r_state <= S_STO;
                                    8'h65: r_state <= S_LDR;
                                    default: r_res.fault <= FAULT_UNK;
                                endcase
                            end
                        endcase
                    end
                end
                S_DRD: r_state <= S_DROW;
                S_DROW: begin
                    r_rowd <= r_fb[w_row];
                    r_state <= S_DXOR;
                end
                S_DXOR: begin
                    if ((r_rowd & w_mask) != '0) r_hit <= 1'b1;
                    if (w_mask != '0) r_chg <= 1'b1;
                    r_fb[w_row] <= r_rowd ^ w_mask;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt + 5'd1 == {1'b0, w_n}) begin
                        r_v[15] <= {7'd0, r_hit || ((r_rowd & w_mask) != '0)};
                        r_state <= S_DONE;
                    end else r_state <= S_DRD;
                end
                S_BCD: begin
                    // digit by digit: subtract tens from the remainder
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_bcd <= (r_rnd >= 8'd90) ? 8'd9 : (r_rnd >= 8'd80) ? 8'd8 :
                                 (r_rnd >= 8'd70) ? 8'd7 : (r_rnd >= 8'd60) ? 8'd6 :
                                 (r_rnd >= 8'd50) ? 8'd5 : (r_rnd >= 8'd40) ? 8'd4 :
                                 (r_rnd >= 8'd30) ? 8'd3 : (r_rnd >= 8'd20) ? 8'd2 :
                                 (r_rnd >= 8'd10) ? 8'd1 : 8'd0;
                    end else if (r_cnt == 5'd1) begin
                        r_bcd <= r_rnd - 8'd10 * r_bcd;
                    end else r_state <= S_DONE;
                end
                S_STO: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[3:0] == w_x) r_state <= S_DONE;
                end
                S_LDR: r_state <= S_LDW;
                S_LDW: begin
                    r_v[r_cnt[3:0]] <= r_mdat;
                    r_cnt <= r_cnt + 5'd1;
                    r_state <= (r_cnt[3:0] == w_x) ? S_DONE : S_LDR;
                end
                S_DONE: begin
                    r_res.next_pc <= r_pc;
                    r_res.index_value <= r_i;
                    r_res.screen_changed <= r_chg;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_next_pc = r_res.next_pc;
    assign o_index_value = r_res.index_value;
    assign o_row_data = r_res.row_data;
    assign o_screen_changed = r_res.screen_changed;
    assign o_key_wait = r_res.key_wait;
    assign o_delay_load = r_res.delay_load;
    assign o_sound_load = r_res.sound_load;
    assign o_timer_value = r_res.timer_value;
    assign o_fault = r_res.fault;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_valid || $past(o_valid)) else $error("result without work");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall) else $error("word taken while busy");
    a_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_delay_load && o_sound_load)) else $error("two timer loads");
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import c8ex_pkg::*;

    localparam logic [3:0] GRP_SYS = 4'h0, GRP_JUMP = 4'h1, GRP_CALL = 4'h2, GRP_SKEQ = 4'h3;
    localparam logic [3:0] GRP_SKNE = 4'h4, GRP_SKREQ = 4'h5, GRP_LOAD = 4'h6, GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU = 4'h8, GRP_SKRNE = 4'h9, GRP_SETI = 4'hA, GRP_JMPV0 = 4'hB;
    localparam logic [3:0] GRP_RAND = 4'hC, GRP_DRAW = 4'hD, GRP_KEY = 4'hE, GRP_MISC = 4'hF;
    localparam logic [15:0] OP_CLS = 16'h00E0, OP_RET = 16'h00EE;
    localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;
    localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
    localparam logic [7:0] FX_GETDLY = 8'h07, FX_WAITKEY = 8'h0A, FX_SETDLY = 8'h15;
    localparam logic [7:0] FX_SETSND = 8'h18, FX_ADDI = 8'h1E, FX_FONT = 8'h29;
    localparam logic [7:0] FX_BCD = 8'h33, FX_STORE = 8'h55, FX_LOADM = 8'h65;
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] instruction;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
        logic [7:0]  delay_now;
        logic [11:0] access_address;
        logic [7:0]  load_data;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_start_address;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_instruction;
    logic [7:0]  i_random_byte;
    logic [15:0] i_keys_down;
    logic [7:0]  i_delay_now;
    logic [11:0] i_access_address;
    logic [7:0]  i_load_data;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_next_pc;
    logic [15:0] o_index_value;
    logic [63:0] o_row_data;
    logic        o_screen_changed;
    logic        o_key_wait;
    logic        o_delay_load;
    logic        o_sound_load;
    logic [7:0]  o_timer_value;
    logic [1:0]  o_fault;

    chip8_instruction_execute_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // machine state mirror
    logic [7:0]  vreg [16];
    logic [15:0] ireg;
    logic [11:0] pc_reg;
    logic [11:0] start_addr;
    int          sp;
    logic [11:0] stk [STACK_DEPTH];
    logic [7:0]  mem [MEM_BYTES];
    bit          mem_ok [MEM_BYTES];
    logic [63:0] rows [SCREEN_H];

    t_result pending_results[$];
    int      mismatches = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      quiet_cycles = 0;

    function automatic t_result run_exec(input t_word w);
        t_result     r;
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy;
        logic [11:0] nnn, pc;
        logic [8:0]  sum;
        logic [63:0] mask;
        logic [7:0]  b;
        logic [11:0] a;
        bit          hit;
        int          k, j, rr;
        r = '0;
        op = w.instruction;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        vx = vreg[x]; vy = vreg[y];
        pc = pc_reg + 12'd2;
        case (op[15:12])
            GRP_SYS: begin
                if (op == OP_CLS) begin
                    for (k = 0; k < SCREEN_H; k++) begin
                        if (rows[k] != 0) r.screen_changed = 1'b1;
                        rows[k] = '0;
                    end
                end else if (op == OP_RET) begin
                    if (sp == 0) r.fault = FAULT_UNDER;
                    else begin
                        sp--;
                        pc = stk[sp];
                    end
                end else r.fault = FAULT_UNK;
            end
            GRP_JUMP: pc = nnn;
            GRP_CALL: begin
                if (sp >= STACK_DEPTH) r.fault = FAULT_OVER;
                else begin
                    stk[sp] = pc;
                    sp++;
                    pc = nnn;
                end
            end
            GRP_SKEQ: if (vx == nn) pc = pc + 12'd2;
            GRP_SKNE: if (vx != nn) pc = pc + 12'd2;
            GRP_SKREQ: begin
                if (n != 0) r.fault = FAULT_UNK;
                else if (vx == vy) pc = pc + 12'd2;
            end
            GRP_LOAD: vreg[x] = nn;
            GRP_ADDI: vreg[x] = vx + nn;
            GRP_ALU: begin
                case (n)
                    ALU_MOV: vreg[x] = vy;
                    ALU_OR: vreg[x] = vx | vy;
                    ALU_AND: vreg[x] = vx & vy;
                    ALU_XOR: vreg[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, vx >= vy};
                    end
                    ALU_SHR: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    ALU_SUBN: begin
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, vy >= vx};
                    end
                    ALU_SHL: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: r.fault = FAULT_UNK;
                endcase
            end
            GRP_SKRNE: begin
                if (n != 0) r.fault = FAULT_UNK;
                else if (vx != vy) pc = pc + 12'd2;
            end
            GRP_SETI: ireg = {4'd0, nnn};
            GRP_JMPV0: pc = nnn + {4'd0, vreg[0]};
            GRP_RAND: vreg[x] = w.random_byte & nn;
            GRP_DRAW: begin
                hit = 1'b0;
                for (k = 0; k < n; k++) begin
                    a = ireg[11:0] + 12'(k);
                    b = mem[a];
                    rr = (vy + k) % SCREEN_H;
                    mask = '0;
                    for (j = 0; j < 8; j++)
                        if (b[7 - j]) mask[63 - ((vx + j) % SCREEN_W)] = 1'b1;
                    if ((rows[rr] & mask) != 0) hit = 1'b1;
                    if (mask != 0) r.screen_changed = 1'b1;
                    rows[rr] ^= mask;
                end
                vreg[15] = {7'd0, hit};
            end
            GRP_KEY: begin
                if (nn == KEY_DOWN) begin
                    if (w.keys_down[vx[3:0]]) pc = pc + 12'd2;
                end else if (nn == KEY_UP) begin
                    if (!w.keys_down[vx[3:0]]) pc = pc + 12'd2;
                end else r.fault = FAULT_UNK;
            end
            default: begin
                case (nn)
                    FX_GETDLY: vreg[x] = w.delay_now;
                    FX_WAITKEY: begin
                        if (w.keys_down == 0) begin
                            pc = pc_reg;
                            r.key_wait = 1'b1;
                        end else begin
                            for (k = 15; k >= 0; k--)
                                if (w.keys_down[k]) vreg[x] = 8'(k);
                        end
                    end
                    FX_SETDLY: begin
                        r.delay_load = 1'b1;
                        r.timer_value = vx;
                    end
                    FX_SETSND: begin
                        r.sound_load = 1'b1;
                        r.timer_value = vx;
                    end
                    FX_ADDI: ireg = ireg + {8'd0, vx};
                    FX_FONT: ireg = 16'(vx[3:0]) * 16'd5;
                    FX_BCD: begin
                        for (k = 0; k < 3; k++) begin
                            a = ireg[11:0] + 12'(k);
                            mem[a] = 8'((k == 0) ? vx / 100 :
                                        (k == 1) ? (vx / 10) % 10 : vx % 10);
                            mem_ok[a] = 1'b1;
                        end
                    end
                    FX_STORE: begin
                        for (k = 0; k <= x; k++) begin
                            a = ireg[11:0] + 12'(k);
                            mem[a] = vreg[k];
                            mem_ok[a] = 1'b1;
                        end
                    end
                    FX_LOADM: begin
                        for (k = 0; k <= x; k++) vreg[k] = mem[ireg[11:0] + 12'(k)];
                    end
                    default: r.fault = FAULT_UNK;
                endcase
            end
        endcase
        pc_reg = pc;
        return r;
    endfunction

    function automatic t_result predict_word(input t_word w);
        t_result r;
        r = '0;
        case (w.mode)
            MODE_EXEC: r = run_exec(w);
            MODE_WRMEM: begin
                mem[w.access_address] = w.load_data;
                mem_ok[w.access_address] = 1'b1;
            end
            MODE_RDROW: begin
                if (w.access_address < SCREEN_H) r.row_data = rows[w.access_address[4:0]];
            end
            default: ;
        endcase
        r.next_pc = pc_reg;
        r.index_value = ireg;
        return r;
    endfunction

    task automatic send_word(input t_word w);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= w.mode;
        i_instruction <= w.instruction;
        i_random_byte <= w.random_byte;
        i_keys_down <= w.keys_down;
        i_delay_now <= w.delay_now;
        i_access_address <= w.access_address;
        i_load_data <= w.load_data;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_word(w));
    endtask

    function automatic t_word rand_word(input logic [1:0] mode, input logic [15:0] op);
        t_word w;
        w.mode = mode;
        w.instruction = op;
        w.random_byte = 8'($urandom);
        w.keys_down = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        w.delay_now = 8'($urandom);
        w.access_address = 12'($urandom);
        w.load_data = 8'($urandom);
        return w;
    endfunction

    task automatic send_op(input logic [15:0] op);
        send_word(rand_word(MODE_EXEC, op));
    endtask

    task automatic send_keyed(input logic [15:0] op, input logic [15:0] keys);
        t_word w;
        w = rand_word(MODE_EXEC, op);
        w.keys_down = keys;
        send_word(w);
    endtask

    task automatic poke(input logic [11:0] addr, input logic [7:0] data);
        t_word w;
        w = rand_word(MODE_WRMEM, 16'($urandom));
        w.access_address = addr;
        w.load_data = data;
        send_word(w);
    endtask

    task automatic read_row(input logic [11:0] row);
        t_word w;
        w = rand_word(MODE_RDROW, 16'($urandom));
        w.access_address = row;
        send_word(w);
    endtask

    // fill unwritten bytes before a sprite or block load reads them
    task automatic fill_mem(input int count);
        logic [11:0] a;
        for (int k = 0; k < count; k++) begin
            a = ireg[11:0] + 12'(k);
            if (!mem_ok[a]) poke(a, 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [11:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_start_address <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        start_addr = addr;
        pc_reg = addr;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_next_pc, o_index_value, o_row_data, o_screen_changed, o_key_wait,
                    o_delay_load, o_sound_load, o_timer_value, o_fault};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: got %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.next_pc !== want.next_pc || got.index_value !== want.index_value ||
                    got.row_data !== want.row_data ||
                    got.screen_changed !== want.screen_changed ||
                    got.key_wait !== want.key_wait || got.delay_load !== want.delay_load ||
                    got.sound_load !== want.sound_load ||
                    got.timer_value !== want.timer_value || got.fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic test_directed();
        write_start(12'hFFF);
        send_op({GRP_LOAD, 4'h0, 8'hFF});
        send_op({GRP_LOAD, 4'h1, 8'h01});
        send_op({GRP_ALU, 4'h0, 4'h1, ALU_ADD});
        send_op({GRP_ALU, 4'h1, 4'h0, ALU_SUB});
        send_op({GRP_ALU, 4'hF, 4'h1, ALU_SUBN});
        send_op({GRP_ALU, 4'h1, 4'h2, ALU_SHR});
        send_op({GRP_LOAD, 4'h3, 8'h80});
        send_op({GRP_ALU, 4'h3, 4'h0, ALU_SHL});
        send_op({GRP_SETI, 12'h200});
        poke(12'h200, 8'hFF);
        poke(12'h201, 8'h81);
        send_op({GRP_LOAD, 4'h4, 8'h3C});
        send_op({GRP_LOAD, 4'h5, 8'h1F});
        send_op({GRP_DRAW, 4'h4, 4'h5, 4'h2});
        read_row(12'd0);
        read_row(12'd31);
        send_op({GRP_DRAW, 4'h4, 4'h5, 4'h1});
        send_op({GRP_DRAW, 4'h4, 4'h5, 4'h0});
        send_op(OP_CLS);
        read_row(12'hFFF);
        send_keyed({GRP_MISC, 4'h6, FX_WAITKEY}, 16'd0);
        send_keyed({GRP_MISC, 4'h6, FX_WAITKEY}, 16'h8000);
        send_keyed({GRP_KEY, 4'h6, KEY_DOWN}, 16'h8000);
        send_keyed({GRP_KEY, 4'h6, KEY_UP}, 16'h8000);
        send_op({GRP_MISC, 4'h0, FX_SETDLY});
        send_op({GRP_MISC, 4'h0, FX_SETSND});
        send_op({GRP_MISC, 4'h2, FX_GETDLY});
        send_op({GRP_MISC, 4'h0, FX_FONT});
        send_op({GRP_SETI, 12'hFFE});
        send_op({GRP_MISC, 4'h0, FX_BCD});
        send_op({GRP_MISC, 4'hF, FX_STORE});
        send_op({GRP_MISC, 4'hF, FX_LOADM});
        send_op({GRP_MISC, 4'h0, FX_ADDI});
        send_op({GRP_SKEQ, 4'h0, 8'hFF});
        send_op({GRP_SKNE, 4'h0, 8'hFF});
        send_op({GRP_SKREQ, 4'h0, 4'h1, 4'h0});
        send_op({GRP_SKRNE, 4'h0, 4'h1, 4'h0});
        send_op({GRP_JMPV0, 12'hFFF});
        send_op({GRP_RAND, 4'h7, 8'hA5});
        send_op({GRP_ADDI, 4'h7, 8'hFF});
        send_op({GRP_JUMP, 12'h000});
        send_op(16'h0123);
        send_op({GRP_SKREQ, 4'h1, 4'h2, 4'h3});
        send_op({GRP_ALU, 4'h1, 4'h2, 4'hF});
        send_op({GRP_KEY, 4'h1, 8'h00});
        send_op({GRP_MISC, 4'h1, 8'hFF});
        send_word(rand_word(MODE_NOP, 16'hFFFF));
    endtask

    task automatic test_stack_limits();
        for (int k = 0; k <= STACK_DEPTH; k++) send_op({GRP_CALL, 12'($urandom)});
        for (int k = 0; k <= STACK_DEPTH + 1; k++) send_op(OP_RET);
    endtask

    function automatic logic [15:0] rand_op();
        logic [3:0] g, x, y;
        logic [7:0] fx_ops [9];
        fx_ops = '{FX_GETDLY, FX_WAITKEY, FX_SETDLY, FX_SETSND, FX_ADDI, FX_FONT,
                   FX_BCD, FX_STORE, FX_LOADM};
        g = 4'($urandom);
        x = 4'($urandom);
        y = 4'($urandom);
        case (g)
            GRP_SYS: begin
                case ($urandom_range(9))
                    0: return OP_CLS;
                    1: return {4'h0, 12'($urandom)};
                    default: return OP_RET;
                endcase
            end
            GRP_SKREQ, GRP_SKRNE:
                return {g, x, y, ($urandom_range(7) == 0) ? 4'($urandom) : 4'h0};
            GRP_ALU: begin
                if ($urandom_range(9) == 0) return {g, x, y, 4'($urandom)};
                return {g, x, y, ($urandom_range(8) == 8) ? ALU_SHL : 4'($urandom_range(7))};
            end
            GRP_SETI:
                return {g, ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(511, 639))};
            GRP_KEY: begin
                if ($urandom_range(9) == 0) return {g, x, 8'($urandom)};
                return {g, x, $urandom_range(1) ? KEY_DOWN : KEY_UP};
            end
            GRP_MISC: begin
                if ($urandom_range(9) == 0) return {g, x, 8'($urandom)};
                return {g, x, fx_ops[$urandom_range(8)]};
            end
            default: return {g, 12'($urandom)};
        endcase
    endfunction

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        logic [15:0] op;
        int          sel;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                op = rand_op();
                if (op[15:12] == GRP_DRAW) fill_mem(op[3:0]);
                if (op[15:12] == GRP_MISC && op[7:0] == FX_LOADM) fill_mem(op[11:8] + 1);
                send_op(op);
            end else if (sel < 90) begin
                poke($urandom_range(1) ? ireg[11:0] + 12'($urandom_range(15)) : 12'($urandom),
                     8'($urandom));
            end else if (sel < 98) begin
                read_row($urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(SCREEN_H - 1)));
            end else begin
                send_word(rand_word(MODE_NOP, 16'($urandom)));
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_start_address <= '0;
        i_valid <= 1'b0;
        i_mode <= MODE_EXEC;
        i_instruction <= '0;
        i_random_byte <= '0;
        i_keys_down <= '0;
        i_delay_now <= '0;
        i_access_address <= '0;
        i_load_data <= '0;
        for (int k = 0; k < 16; k++) vreg[k] = '0;
        for (int k = 0; k < SCREEN_H; k++) rows[k] = '0;
        for (int k = 0; k < MEM_BYTES; k++) begin
            mem[k] = '0;
            mem_ok[k] = 1'b0;
        end
        ireg = '0;
        start_addr = START_RESET;
        pc_reg = START_RESET;
        sp = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_stack_limits();
        i_valid <= 1'b0;
        wait_idle();
        write_start(12'h000);
        test_random(560, 18, 77);
        wait_idle();
        write_start(12'($urandom));
        test_random(560, 77, 18);
        wait_idle();
        write_start(START_RESET);
        test_random(580, 0, 0);
        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
